// ===== hdl/chm_pkg.sv =====
// Package for the hit merge table: table sizing, request and result
// payload types, stored entry layout, status codes and sequencer states.
// No dependencies.
`default_nettype none

package chm_pkg;

  // Table sizing.
  localparam int TABLE_DEPTH = 64;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NUM_COUNTS  = 6;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_CREATED     = 3'd0,
    ST_MERGED      = 3'd1,
    ST_DISCARDED   = 3'd2,
    ST_FULL_DROP   = 3'd3,
    ST_DRAINED     = 3'd4,
    ST_DRAIN_EMPTY = 3'd5
  } stat_t;

  // Request function codes.
  typedef enum logic {
    FN_HIT   = 1'b0,
    FN_DRAIN = 1'b1
  } func_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DRAIN,
    S_EMIT
  } state_t;

  // Input request payload.
  typedef struct packed {
    func_t       func;
    logic [30:0] event_id;
    logic [31:0] volume_id;
    logic        is_electron;
    logic [31:0] energy;
    logic [47:0] hit_time;
    logic [7:0]  crystal_compton;
    logic [7:0]  crystal_rayleigh;
    logic [7:0]  crystal_conv;
    logic [7:0]  phantom_compton;
    logic [7:0]  phantom_rayleigh;
    logic [7:0]  septal_hits;
  } in_t;

  // Result payload.
  typedef struct packed {
    stat_t       status;
    logic [30:0] out_event_id;
    logic [31:0] out_volume_id;
    logic [31:0] out_energy;
    logic [47:0] out_time;
    logic [7:0]  out_crystal_compton;
    logic [7:0]  out_crystal_rayleigh;
    logic [7:0]  out_crystal_conv;
    logic [7:0]  out_phantom_compton;
    logic [7:0]  out_phantom_rayleigh;
    logic [7:0]  out_septal_hits;
    logic        last;
  } out_t;

  // One stored table entry. Count 0 is the crystal Compton count, then
  // crystal Rayleigh, crystal conversion, phantom Compton, phantom
  // Rayleigh and septal hits.
  typedef struct packed {
    logic [30:0]                      event_id;
    logic [31:0]                      volume_id;
    logic [31:0]                      energy;
    logic [47:0]                      hit_time;
    logic [NUM_COUNTS-1:0][7:0]       counts;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== hdl/chm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module chm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                           clk,
  input  wire logic                                           we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]                               wdata,
  input  wire logic                                           re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic      [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/compton_hit_merge_table_top.sv =====
// Hit merge table top level: request sequencer, merge datapath, output register.
// Depends on chm_pkg and chm_ram.
// Photon hit, or electron or drain on an empty table: the result goes to a pending register,
// then to the output register when that is free. Electron hit on N entries: one entry read per
// cycle, newest first, until a match or entry 0, then the result is emitted the same way.
// Drain of N entries: one result per cycle; output stalls hold it.
// In_ready is high only between requests; reset empties the table, RAM is not cleared.
`default_nettype none

module compton_hit_merge_table_top (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire chm_pkg::in_t  in_req,
  output logic               out_valid,
  input  wire logic          out_ready,
  output chm_pkg::out_t      out_res
);

  import chm_pkg::*;

  // Sequencer and table state.
  state_t            state_r, state_nxt;
  in_t               req_r;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]  total_r, total_nxt;
  out_t              res_r, res_nxt;
  out_t              out_r, out_val;
  logic              out_valid_r;
  logic              out_load;

  // RAM port signals.
  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t            ram_wdata, rd_entry;

  // Derived conditions.
  logic              in_fire, out_free, rd_match, at_first, drain_last;
  logic              table_full, table_empty;
  logic [CNT_W-1:0]  total_m1;
  logic [IDX_W-1:0]  last_idx;
  entry_t            req_entry, in_entry, merged;
  logic [32:0]       energy_sum;

  // Pack a request's hit fields into the entry layout.
  function automatic entry_t to_entry(input in_t r);
    entry_t e;
    e.event_id  = r.event_id;
    e.volume_id = r.volume_id;
    e.energy    = r.energy;
    e.hit_time  = r.hit_time;
    e.counts[0] = r.crystal_compton;
    e.counts[1] = r.crystal_rayleigh;
    e.counts[2] = r.crystal_conv;
    e.counts[3] = r.phantom_compton;
    e.counts[4] = r.phantom_rayleigh;
    e.counts[5] = r.septal_hits;
    return e;
  endfunction

  // Build a result from an entry.
  function automatic out_t mk_res(input stat_t st, input entry_t e, input logic lst);
    out_t o;
    o.status               = st;
    o.out_event_id         = e.event_id;
    o.out_volume_id        = e.volume_id;
    o.out_energy           = e.energy;
    o.out_time             = e.hit_time;
    o.out_crystal_compton  = e.counts[0];
    o.out_crystal_rayleigh = e.counts[1];
    o.out_crystal_conv     = e.counts[2];
    o.out_phantom_compton  = e.counts[3];
    o.out_phantom_rayleigh = e.counts[4];
    o.out_septal_hits      = e.counts[5];
    o.last                 = lst;
    return o;
  endfunction

  // Table storage.
  chm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd_entry)
  );

  // Handshake and table conditions.
  assign in_fire     = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign table_empty = (total_r == '0);
  assign table_full  = (total_r == CNT_W'(TABLE_DEPTH));
  assign total_m1    = total_r - CNT_W'(1);
  assign last_idx    = total_m1[IDX_W-1:0];
  assign at_first    = (idx_r == '0);
  assign drain_last  = (CNT_W'(idx_r) + CNT_W'(1) == total_r);
  assign in_entry    = to_entry(in_req);
  assign req_entry   = to_entry(req_r);
  assign rd_match    = (rd_entry.volume_id == req_r.volume_id) &&
                       (rd_entry.event_id == req_r.event_id);

  // Merge unit: saturating energy add, earlier time, larger counts.
  assign energy_sum = {1'b0, rd_entry.energy} + {1'b0, req_r.energy};

  always_comb begin
    merged           = rd_entry;
    merged.energy    = energy_sum[32] ? 32'hFFFF_FFFF : energy_sum[31:0];
    merged.hit_time  = (req_r.hit_time < rd_entry.hit_time) ? req_r.hit_time
                                                            : rd_entry.hit_time;
    for (int k = 0; k < NUM_COUNTS; k++) begin
      merged.counts[k] = (req_entry.counts[k] > rd_entry.counts[k])
                         ? req_entry.counts[k] : rd_entry.counts[k];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req.func == FN_DRAIN) begin
            state_nxt = table_empty ? S_EMIT : S_DRAIN;
          end else if (in_req.is_electron) begin
            state_nxt = table_empty ? S_EMIT : S_SEARCH;
          end else begin
            state_nxt = S_EMIT;
          end
        end
      end
      S_SEARCH: begin
        if (rd_match || at_first) begin
          state_nxt = S_EMIT;
        end
      end
      S_DRAIN: begin
        if (out_free && drain_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Sequencer outputs: RAM controls, pending result, index and count updates.
  always_comb begin
    in_ready  = (state_r == S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = merged;
    ram_re    = 1'b0;
    ram_raddr = idx_r;
    res_nxt   = res_r;
    idx_nxt   = idx_r;
    total_nxt = total_r;
    out_load  = 1'b0;
    out_val   = res_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_req.func == FN_DRAIN) begin
            if (table_empty) begin
              res_nxt = mk_res(ST_DRAIN_EMPTY, '0, 1'b1);
            end else begin
              ram_re    = 1'b1;
              ram_raddr = '0;
              idx_nxt   = '0;
            end
          end else if (in_req.is_electron) begin
            if (table_empty) begin
              res_nxt = mk_res(ST_DISCARDED, in_entry, 1'b1);
            end else begin
              ram_re    = 1'b1;
              ram_raddr = last_idx;
              idx_nxt   = last_idx;
            end
          end else if (table_full) begin
            res_nxt = mk_res(ST_FULL_DROP, in_entry, 1'b1);
          end else begin
            ram_we    = 1'b1;
            ram_waddr = total_r[IDX_W-1:0];
            ram_wdata = in_entry;
            total_nxt = total_r + CNT_W'(1);
            res_nxt   = mk_res(ST_CREATED, in_entry, 1'b1);
          end
        end
      end
      S_SEARCH: begin
        if (rd_match) begin
          ram_we  = 1'b1;
          res_nxt = mk_res(ST_MERGED, merged, 1'b1);
        end else if (at_first) begin
          res_nxt = mk_res(ST_DISCARDED, req_entry, 1'b1);
        end else begin
          ram_re    = 1'b1;
          ram_raddr = idx_r - IDX_W'(1);
          idx_nxt   = idx_r - IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_val  = mk_res(ST_DRAINED, rd_entry, drain_last);
          if (drain_last) begin
            total_nxt = '0;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + IDX_W'(1);
            idx_nxt   = idx_r + IDX_W'(1);
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_r <= in_req;
    end
    idx_r <= idx_nxt;
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= out_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

`ifndef ASSERT_OFF
  // The entry count never exceeds the table depth.
  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // Searching and draining only touch valid entries.
  a_search_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_DRAIN) |-> (CNT_W'(idx_r) < total_r))
    else $error("table index outside valid entries");

  // A stored photon hit grows the table by exactly one.
  a_create_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_req.func == FN_HIT && !in_req.is_electron && !table_full)
    |=> (total_r == $past(total_r) + CNT_W'(1)))
    else $error("created entry did not advance the count");

  // Handing out the final drained entry empties the table.
  a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN && out_free && drain_last) |=> (total_r == '0))
    else $error("drain did not empty the table");

  // The RAM is written only when a request is stored or merged.
  a_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_IDLE && in_fire) || (state_r == S_SEARCH && rd_match)))
    else $error("unexpected table write");
`endif

endmodule

`default_nettype wire
